// File: src/mec_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Mandelbrot escape-time counter.
// No dependencies; imported by the top level and the port checker.
package mec_pkg;

    // Fixed-point format of all complex values: signed Q4.28
    localparam int FRAC_BITS    = 28;
    localparam int Q_BITS       = 32;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int ITER_BITS    = 8;

    // Width of the pre-saturation sums (wide enough for every case)
    localparam int SUM_BITS = 49;

    localparam logic signed [SUM_BITS-1:0] SUM_Q_MAX = 49'sd2147483647;
    localparam logic signed [SUM_BITS-1:0] SUM_Q_MIN = -49'sd2147483648;

    // Register reset values
    localparam logic [31:0] RST_START = 32'hD000_0000;   // -3.0
    localparam logic [31:0] RST_STEP  = 32'h0008_0100;
    localparam logic [31:0] RST_LIMIT = 32'h4000_0000;   // 4.0
    localparam logic [7:0]  RST_MAX_ITER = 8'hFF;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_REAL_START = 3'd0,
        REG_IMAG_START = 3'd1,
        REG_REAL_STEP  = 3'd2,
        REG_IMAG_STEP  = 3'd3,
        REG_ESC_LIMIT  = 3'd4,
        REG_MAX_ITER   = 3'd5
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COL_Q,
        ST_COL_R,
        ST_ROW_Q,
        ST_ROW_R,
        ST_C_RE,
        ST_C_IM,
        ST_Z_INIT,
        ST_IT_RR,
        ST_IT_II,
        ST_IT_RI,
        ST_IT_UPD,
        ST_DONE
    } state_t;

    // Clamp a wide sum to the Q4.28 range
    function automatic logic signed [Q_BITS-1:0] sat_q(input logic signed [SUM_BITS-1:0] v);
        logic signed [SUM_BITS-1:0] r;
        begin
            if (v > SUM_Q_MAX) begin
                r = SUM_Q_MAX;
            end else if (v < SUM_Q_MIN) begin
                r = SUM_Q_MIN;
            end else begin
                r = v;
            end
            return r[Q_BITS-1:0];
        end
    endfunction

endpackage

// File: src/mandelbrot_escape_count.sv
`timescale 1ns / 1ps
// Mandelbrot escape-time counter: pixel in, iteration count out.
// Depends on mec_pkg; one shared 33x33 signed multiplier under a sequencer.
//
//  Channel  | Ports                                   | Direction
//  ---------+-----------------------------------------+----------
//  pixel    | s_valid s_ready s_pixel_column/row      | in
//  result   | m_valid m_ready m_iteration_count       | out
//  config   | cfg_valid cfg_ready cfg_index cfg_data  | in
//
// An item passes from acceptance to result through 7 setup steps for index
// wrap and c, four steps per iteration (at most max_iterations of them),
// since the one multiplier forms zr*zr, zi*zi and zr*zi in turn, then three
// steps for the final escape test and one to hand the count over. s_ready is
// high only while the sequencer is idle. A finished count waits in the output
// register; the next pixel is taken meanwhile, and only a second finished
// count stalls on m_ready.
// Reset (aresetn low, synchronous) restores the register defaults.
module mandelbrot_escape_count #(
    parameter int IMAGE_SIDE = 2048,
    parameter int COUNT_BITS = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [10:0]                          s_pixel_column,
    input  logic [10:0]                          s_pixel_row,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [COUNT_BITS-1:0]                m_iteration_count,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mec_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [mec_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import mec_pkg::*;

    // Index wrap by reciprocal: q = (v * RECIP) >> RECIP_SHIFT is q or q-1
    localparam int RECIP_SHIFT = 24;
    localparam int MOD_RECIP   = (1 << RECIP_SHIFT) / IMAGE_SIDE;
    localparam logic [16:0] SIDE_W = 17'(IMAGE_SIDE);

    // Configuration registers
    logic signed [31:0] real_start_reg, imag_start_reg, real_step_reg, imag_step_reg;
    logic [31:0]        esc_limit_reg;
    logic [7:0]         max_iter_reg;

    // Sequencer and datapath registers
    state_t             state_reg, state_next;
    logic [10:0]        col_reg, col_next, row_reg, row_next;
    logic signed [63:0] prod_reg;
    logic signed [63:0] rr_reg, rr_next, ii_reg, ii_next;
    logic signed [31:0] cr_reg, cr_next, ci_reg, ci_next;
    logic signed [31:0] zr_reg, zr_next, zi_reg, zi_next;
    logic [7:0]         count_reg, count_next;
    logic [7:0]         out_count_reg, out_count_next;
    logic               m_valid_reg, m_valid_next;

    // Shared multiplier operands
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_full;

    // Helper terms
    logic [10:0]        mod_src, mod_rem, mod_fixed;
    logic [63:0]        mag, limit;
    logic               stop;
    logic signed [63:0] zdiff;
    logic [15:0]        count_wide;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign count_wide = 16'(out_count_reg);
    assign m_iteration_count = count_wide[COUNT_BITS-1:0];

    // Take configuration writes; unknown indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            real_start_reg <= RST_START;
            imag_start_reg <= RST_START;
            real_step_reg  <= RST_STEP;
            imag_step_reg  <= RST_STEP;
            esc_limit_reg  <= RST_LIMIT;
            max_iter_reg   <= RST_MAX_ITER;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_REAL_START: real_start_reg <= cfg_data;
                REG_IMAG_START: imag_start_reg <= cfg_data;
                REG_REAL_STEP:  real_step_reg  <= cfg_data;
                REG_IMAG_STEP:  imag_step_reg  <= cfg_data;
                REG_ESC_LIMIT:  esc_limit_reg  <= cfg_data;
                REG_MAX_ITER:   max_iter_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Finish the index wrap: remainder is in [0, 2*side), subtract once
    assign mod_src = (state_reg == ST_ROW_Q) ? col_reg : row_reg;
    assign mod_rem = mod_src - prod_reg[10:0];
    always_comb begin
        mod_fixed = mod_rem;
        if ({6'b0, mod_rem} >= SIDE_W) begin
            mod_fixed = 11'({6'b0, mod_rem} - SIDE_W);
        end
    end

    // Escape test: |z|^2 against limit scaled to Q8.56
    assign mag   = 64'(rr_reg) + 64'(prod_reg);
    assign limit = {4'b0, esc_limit_reg, 28'b0};
    assign stop  = !(mag < limit) || (count_reg >= max_iter_reg);
    assign zdiff = rr_reg - ii_reg;

    // Shared multiplier, registered output
    assign mul_full = mul_a * mul_b;

    // Next state, multiplier operand select and datapath updates
    always_comb begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        rr_next        = rr_reg;
        ii_next        = ii_reg;
        cr_next        = cr_reg;
        ci_next        = ci_reg;
        zr_next        = zr_reg;
        zi_next        = zi_reg;
        count_next     = count_reg;
        out_count_next = out_count_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        mul_a          = '0;
        mul_b          = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    col_next   = s_pixel_column;
                    row_next   = s_pixel_row;
                    state_next = ST_COL_Q;
                end
            end
            ST_COL_Q: begin
                mul_a      = $signed({22'b0, col_reg});
                mul_b      = 33'(MOD_RECIP);
                state_next = ST_COL_R;
            end
            ST_COL_R: begin
                mul_a      = $signed({22'b0, prod_reg[34:24]});
                mul_b      = 33'(IMAGE_SIDE);
                state_next = ST_ROW_Q;
            end
            ST_ROW_Q: begin
                col_next   = mod_fixed;
                mul_a      = $signed({22'b0, row_reg});
                mul_b      = 33'(MOD_RECIP);
                state_next = ST_ROW_R;
            end
            ST_ROW_R: begin
                mul_a      = $signed({22'b0, prod_reg[34:24]});
                mul_b      = 33'(IMAGE_SIDE);
                state_next = ST_C_RE;
            end
            ST_C_RE: begin
                row_next   = mod_fixed;
                mul_a      = $signed({22'b0, col_reg});
                mul_b      = {real_step_reg[31], real_step_reg};
                state_next = ST_C_IM;
            end
            ST_C_IM: begin
                cr_next    = sat_q(SUM_BITS'(real_start_reg) + $signed(prod_reg[48:0]));
                mul_a      = $signed({22'b0, row_reg});
                mul_b      = {imag_step_reg[31], imag_step_reg};
                state_next = ST_Z_INIT;
            end
            ST_Z_INIT: begin
                ci_next    = sat_q(SUM_BITS'(imag_start_reg) + $signed(prod_reg[48:0]));
                zr_next    = '0;
                zi_next    = '0;
                count_next = '0;
                state_next = ST_IT_RR;
            end
            ST_IT_RR: begin
                mul_a      = {zr_reg[31], zr_reg};
                mul_b      = {zr_reg[31], zr_reg};
                state_next = ST_IT_II;
            end
            ST_IT_II: begin
                rr_next    = prod_reg;
                mul_a      = {zi_reg[31], zi_reg};
                mul_b      = {zi_reg[31], zi_reg};
                state_next = ST_IT_RI;
            end
            ST_IT_RI: begin
                ii_next = prod_reg;
                mul_a   = {zr_reg[31], zr_reg};
                mul_b   = {zi_reg[31], zi_reg};
                if (stop) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_IT_UPD;
                end
            end
            ST_IT_UPD: begin
                // Products floor-shift back to Q4.28; 2*zr*zi uses one bit less
                zr_next    = sat_q(SUM_BITS'(zdiff >>> FRAC_BITS) + SUM_BITS'(cr_reg));
                zi_next    = sat_q(SUM_BITS'(prod_reg >>> (FRAC_BITS - 1)) + SUM_BITS'(ci_reg));
                count_next = count_reg + 8'd1;
                state_next = ST_IT_RR;
            end
            ST_DONE: begin
                // Hold the count until the output register is free
                if (!m_valid_reg || m_ready) begin
                    out_count_next = count_reg;
                    m_valid_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        col_reg       <= col_next;
        row_reg       <= row_next;
        prod_reg      <= mul_full[63:0];
        rr_reg        <= rr_next;
        ii_reg        <= ii_next;
        cr_reg        <= cr_next;
        ci_reg        <= ci_next;
        zr_reg        <= zr_next;
        zi_reg        <= zi_next;
        count_reg     <= count_next;
        out_count_reg <= out_count_next;
    end

endmodule

// File: src/mec_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the Mandelbrot escape-time counter, with its bind.
// Depends on mec_pkg for the configuration port widths.
module mec_checker #(
    parameter int COUNT_BITS = 8
) (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic [10:0]                          s_pixel_column,
    input logic [10:0]                          s_pixel_row,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic [COUNT_BITS-1:0]                m_iteration_count,
    input logic                                 cfg_valid,
    input logic                                 cfg_ready,
    input logic [mec_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input logic [mec_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import mec_pkg::*;

    logic s_fire;
    assign s_fire = s_valid && s_ready;

    // Reset leaves the block idle and empty
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> (s_ready && !m_valid))
        else $error("block not idle after reset");

    // Stalled result holds its count
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_iteration_count)))
        else $error("stalled result dropped or changed");

    // Busy right after a pixel transaction
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_ready)
        else $error("new pixel taken while computing");

    // A pixel transaction is not directly followed by a rising result
    a_min_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (!$rose(m_valid) ##1 !$rose(m_valid)))
        else $error("result appeared too early");

endmodule

bind mandelbrot_escape_count mec_checker #(.COUNT_BITS(COUNT_BITS)) u_mec_checker (.*);

// File: tb/tb_mandelbrot_escape_count.sv
`timescale 1ns / 1ps
// Self-checking testbench for mandelbrot_escape_count: pixels in, iteration counts out.
// Depends on mec_pkg and the RTL top level; predicts every count in Q4.28 fixed point.
module tb_mandelbrot_escape_count;
    import mec_pkg::*;

    localparam int IMAGE_SIDE        = 2048;
    localparam int LONG_HOLD_CYCLES  = 1500;
    localparam int WATCHDOG_LIMIT    = 20000;
    localparam int TAIL_CYCLES       = 1100;

    // Register indexes that the block does not decode
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = 3'd7;

    localparam longint Q4_28_MAX = 64'sd2147483647;
    localparam longint Q4_28_MIN = -64'sd2147483648;

    typedef enum logic [1:0] {
        SINK_ALWAYS,
        SINK_RANDOM,
        SINK_PATTERN
    } sink_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [10:0] s_pixel_column = '0;
    logic [10:0] s_pixel_row = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_iteration_count;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    // Local copy of the plane mapping and iteration limits
    logic signed [31:0] plane_re0     = RST_START;
    logic signed [31:0] plane_im0     = RST_START;
    logic signed [31:0] plane_re_step = RST_STEP;
    logic signed [31:0] plane_im_step = RST_STEP;
    logic [31:0]        bailout_sq    = RST_LIMIT;
    logic [7:0]         iter_cap      = RST_MAX_ITER;

    logic [7:0] pending_counts[$];
    int         fail_count = 0;

    // Sender pacing and receiver stall control
    bit         bursty = 1'b0;
    int         burst_left = 0;
    sink_mode_t sink_mode = SINK_ALWAYS;
    int         long_holds_requested = 0;
    int         long_holds_served = 0;
    int         hold_left = 0;
    logic [12:0] sink_pattern = 13'b1011011101101;
    int         quiet_cycles = 0;

    mandelbrot_escape_count u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_pixel_column    (s_pixel_column),
        .s_pixel_row       (s_pixel_row),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_iteration_count (m_iteration_count),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Clamp a wide value to the Q4.28 range
    function automatic longint clamp_q4_28(input longint v);
        if (v > Q4_28_MAX) begin
            return Q4_28_MAX;
        end else if (v < Q4_28_MIN) begin
            return Q4_28_MIN;
        end
        return v;
    endfunction

    // Iterate z = z*z + c for one pixel and return the escape count
    function automatic logic [7:0] escape_count(input logic [10:0] col, input logic [10:0] row);
        longint          c_re, c_im, z_re, z_im, re_sq, im_sq, next_re, next_im;
        longint unsigned mag_sq, bailout;
        int unsigned     steps;
        c_re = clamp_q4_28(longint'(plane_re0)
                           + (longint'(col) % IMAGE_SIDE) * longint'(plane_re_step));
        c_im = clamp_q4_28(longint'(plane_im0)
                           + (longint'(row) % IMAGE_SIDE) * longint'(plane_im_step));
        z_re = 0;
        z_im = 0;
        steps = 0;
        bailout = bailout_sq;
        bailout = bailout << FRAC_BITS;
        forever begin
            re_sq = z_re * z_re;
            im_sq = z_im * z_im;
            mag_sq = re_sq + im_sq;
            if (mag_sq >= bailout || steps >= iter_cap) break;
            // Floor the scaled products, then saturate the sums with c
            next_re = ((re_sq - im_sq) >>> FRAC_BITS) + c_re;
            next_im = ((z_re * z_im) >>> (FRAC_BITS - 1)) + c_im;
            z_re = clamp_q4_28(next_re);
            z_im = clamp_q4_28(next_im);
            steps++;
        end
        return steps[7:0];
    endfunction

    // Offer one pixel, hold it until accepted, and queue its expected count
    task automatic push_pixel(input logic [10:0] col, input logic [10:0] row);
        s_valid        <= 1'b1;
        s_pixel_column <= col;
        s_pixel_row    <= row;
        do @(posedge aclk); while (!(s_valid && s_ready));
        pending_counts.push_back(escape_count(col, row));
    endtask

    // Drop valid between bursts for a random gap, occasionally a long one
    task automatic pace_sender();
        int gap;
        if (bursty) begin
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 9) == 0) begin
                    gap = $urandom_range(40, 1100);
                end else begin
                    gap = $urandom_range(1, 40);
                end
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic push_random_pixels(input int count);
        for (int i = 0; i < count; i++) begin
            push_pixel(11'($urandom_range(0, IMAGE_SIDE - 1)),
                       11'($urandom_range(0, IMAGE_SIDE - 1)));
            pace_sender();
        end
    endtask

    // Stop offering and wait until every queued count has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write one register and mirror it locally; valid is left high for the caller
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        case (idx)
            REG_REAL_START: plane_re0     = data;
            REG_IMAG_START: plane_im0     = data;
            REG_REAL_STEP:  plane_re_step = data;
            REG_IMAG_STEP:  plane_im_step = data;
            REG_ESC_LIMIT:  bailout_sq    = data;
            REG_MAX_ITER:   iter_cap      = data[7:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [31:0] re0, input logic [31:0] im0,
                               input logic [31:0] re_step, input logic [31:0] im_step,
                               input logic [31:0] limit, input logic [7:0] cap);
        wait_drained();
        write_reg(REG_REAL_START, re0);
        write_reg(REG_IMAG_START, im0);
        write_reg(REG_REAL_STEP, re_step);
        write_reg(REG_IMAG_STEP, im_step);
        write_reg(REG_ESC_LIMIT, limit);
        write_reg(REG_MAX_ITER, {24'b0, cap});
        cfg_valid <= 1'b0;
    endtask

    task automatic load_defaults();
        load_config(RST_START, RST_START, RST_STEP, RST_STEP, RST_LIMIT, RST_MAX_ITER);
    endtask

    // Reset values: image corners, the set interior and alternating index bits
    task automatic test_reset_defaults();
        push_pixel(11'd0, 11'd0);
        push_pixel(11'd2047, 11'd2047);
        push_pixel(11'd0, 11'd2047);
        push_pixel(11'd2047, 11'd0);
        push_pixel(11'd1536, 11'd1536);
        push_pixel(11'd1100, 11'd1536);
        push_pixel(11'h555, 11'h2AA);
        push_pixel(11'h2AA, 11'h555);
        wait_drained();
    endtask

    // Zero cap, cap of one, and a zero escape limit
    task automatic test_cap_and_limit();
        load_config(RST_START, RST_START, RST_STEP, RST_STEP, RST_LIMIT, 8'd0);
        push_pixel(11'd1536, 11'd1536);
        push_pixel(11'd0, 11'd0);
        load_config(RST_START, RST_START, RST_STEP, RST_STEP, RST_LIMIT, 8'd1);
        push_pixel(11'd1536, 11'd1536);
        load_config(RST_START, RST_START, RST_STEP, RST_STEP, 32'h0, 8'd255);
        push_pixel(11'd1536, 11'd1536);
        wait_drained();
    endtask

    // Saturation of c and of z on both signs, first at the widest escape limit, then at the default one
    task automatic test_saturation();
        load_config(32'hC000_0000, 32'hC000_0000, 32'h0400_0000, 32'h0400_0000,
                    32'hFFFF_FFFF, 8'd255);
        push_pixel(11'd26, 11'd26);
        push_pixel(11'd2, 11'd16);
        push_pixel(11'd16, 11'd4);
        push_pixel(11'd22, 11'd16);
        push_pixel(11'd2047, 11'd2047);
        push_pixel(11'd0, 11'd0);
        load_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                    RST_LIMIT, 8'd255);
        push_pixel(11'd0, 11'd0);
        push_pixel(11'd2047, 11'd2047);
        push_pixel(11'd1, 11'd1);
        wait_drained();
    endtask

    // Writes to undecoded indexes must leave every register alone
    task automatic test_spare_indexes();
        load_defaults();
        write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_B, 32'h0000_0000);
        cfg_valid <= 1'b0;
        push_pixel(11'd1536, 11'd1536);
        push_pixel(11'd0, 11'd0);
        wait_drained();
    endtask

    task automatic test_random_default();
        load_defaults();
        bursty     = 1'b1;
        sink_mode <= SINK_RANDOM;
        push_random_pixels(700);
        wait_drained();
    endtask

    // Random views near the set, one at full cap, one with noise registers
    task automatic test_random_planes();
        logic [31:0] re0, im0, re_step, im_step, limit;
        logic [7:0]  cap;
        for (int phase = 0; phase < 5; phase++) begin
            re0     = int'($urandom_range(0, 671088640)) - 590558003;
            im0     = int'($urandom_range(0, 536870912)) - 402653184;
            re_step = $urandom_range(1, 1 << 19);
            im_step = $urandom_range(1, 1 << 19);
            if ($urandom_range(0, 1)) re_step = -re_step;
            if ($urandom_range(0, 1)) im_step = -im_step;
            limit   = ($urandom_range(0, 1)) ? RST_LIMIT : $urandom_range(1 << 28, 32'hFFFF_FFFF);
            cap     = (phase == 3) ? 8'd255 : 8'($urandom_range(1, 64));
            if (phase == 4) begin
                re0     = $urandom();
                im0     = $urandom();
                re_step = $urandom();
                im_step = $urandom();
                limit   = $urandom();
                cap     = 8'($urandom_range(0, 255));
            end
            load_config(re0, im0, re_step, im_step, limit, cap);
            // Phase 2 runs with neither side idling
            bursty     = (phase != 2);
            sink_mode <= (phase == 2) ? SINK_ALWAYS : ((phase % 2) ? SINK_RANDOM : SINK_PATTERN);
            push_random_pixels(200);
        end
        wait_drained();
    endtask

    // Receiver holds off long while the sender keeps offering pixels
    task automatic test_full_backpressure();
        load_defaults();
        bursty                = 1'b0;
        sink_mode            <= SINK_ALWAYS;
        long_holds_requested <= long_holds_requested + 1;
        push_random_pixels(150);
        wait_drained();
    endtask

    // Sender pauses until every count is back, then resumes
    task automatic test_drain_pause();
        bursty     = 1'b1;
        sink_mode <= SINK_PATTERN;
        push_random_pixels(50);
        wait_drained();
        push_random_pixels(50);
        wait_drained();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_cap_and_limit();
        test_saturation();
        test_spare_indexes();
        test_random_default();
        test_random_planes();
        test_full_backpressure();
        test_drain_pause();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_counts.size() != 0) begin
            $error("iteration_count: %0d expected counts never arrived", pending_counts.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("PASS mandelbrot_escape_count");
        end else begin
            $display("FAIL mandelbrot_escape_count");
        end
        $finish;
    end

    // Drive m_ready: long hold first, then the selected stall style
    always @(posedge aclk) begin
        if (long_holds_served != long_holds_requested) begin
            long_holds_served <= long_holds_requested;
            hold_left         <= LONG_HOLD_CYCLES;
            m_ready           <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            case (sink_mode)
                SINK_RANDOM:  m_ready <= ($urandom_range(0, 99) < 65);
                SINK_PATTERN: begin
                    m_ready      <= sink_pattern[0];
                    sink_pattern <= {sink_pattern[0], sink_pattern[12:1]};
                end
                default:      m_ready <= 1'b1;
            endcase
        end
    end

    // Compare each delivered count with the oldest expectation
    always @(posedge aclk) begin : count_checker
        logic [7:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_counts.size() == 0) begin
                $error("iteration_count: no count expected, got %0d", m_iteration_count);
                fail_count++;
            end else begin
                want = pending_counts.pop_front();
                if (m_iteration_count !== want) begin
                    $error("iteration_count: expected %0d, got %0d", want, m_iteration_count);
                    fail_count++;
                end
            end
        end
    end

    // End the run if no channel moves a transaction for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("FAIL mandelbrot_escape_count");
                $finish;
            end
        end
    end

endmodule
